// ===== rtl/tm_pkg.sv =====
// Shared types, widths and status codes of the triangle metrics engine.
package tm_pkg;

  localparam int SIDE_W        = 16;
  localparam int FRAC_BITS_DEF = 4;
  localparam int STATUS_W      = 2;
  localparam int PER_W         = SIDE_W + 2;      // a+b+c
  localparam int DIF_W         = SIDE_W + 1;      // b+c-a, b+c, 2a
  localparam int P1_W          = 2 * SIDE_W + 3;  // per * (b+c-a)
  localparam int P2_W          = 2 * SIDE_W + 2;  // (a+c-b) * (a+b-c)
  localparam int SQ_W          = 2 * SIDE_W;      // squares and side products
  localparam int MED_W         = 2 * SIDE_W + 2;  // 2b^2 + 2c^2 - a^2
  localparam int SQ_IN_W       = 4 * SIDE_W + 2;  // radicands
  localparam int ROOT_W        = SQ_IN_W / 2;
  localparam int MET_W         = 17;
  localparam int AREA_W        = 27;
  localparam int QUEUE_DEPTH   = 4;
  localparam int IN_DATA_W     = 3 * SIDE_W;
  localparam int OUT_DATA_W    = STATUS_W + PER_W + AREA_W + 9 * MET_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_INEQ = 2'd2
  } tm_status_e;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    tm_status_e         status;
    logic [SIDE_W-1:0]  a;
    logic [SIDE_W-1:0]  b;
    logic [SIDE_W-1:0]  c;
    logic [PER_W-1:0]   per;
    logic [DIF_W-1:0]   da;
    logic [DIF_W-1:0]   db;
    logic [DIF_W-1:0]   dc;
  } tm_item_t;

  // Result, last member lowest: status sits in bit 0 upwards.
  typedef struct packed {
    logic [MET_W-1:0]   bis_c;
    logic [MET_W-1:0]   bis_b;
    logic [MET_W-1:0]   bis_a;
    logic [MET_W-1:0]   med_c;
    logic [MET_W-1:0]   med_b;
    logic [MET_W-1:0]   med_a;
    logic [MET_W-1:0]   hgt_c;
    logic [MET_W-1:0]   hgt_b;
    logic [MET_W-1:0]   hgt_a;
    logic [AREA_W-1:0]  area;
    logic [PER_W-1:0]   per;
    tm_status_e         status;
  } tm_result_t;

endpackage

// ===== rtl/triangle_metrics.sv =====
// Top level of the triangle metrics engine: front end, queue, back end.
//
//  channel  dir  beat                    tdata fields, lowest bit up
//  s_axis   in   one triangle            side_a, side_b, side_c (16 bits each)
//  m_axis   out  one result per triangle status, perimeter, area, height_a..c,
//                                        median_a..c, bisector_a..c (200 bits)
//
// One triangle per cycle is taken while the result side keeps up.
// Items pass the front register, queue, product stages, root pipeline (one bit
// per stage), divider pipeline (one quotient bit per stage) and result register.
// Reset clears all valid flags and queue pointers; datapath registers hold junk.
// A stalled result freezes the back end; the four-entry queue and front
// register keep taking transfers until full.
module triangle_metrics import tm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // side_a [15:0], side_b [31:16], side_c [47:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status [1:0], perimeter [19:2], area [46:20], height_a [63:47],
  // height_b [80:64], height_c [97:81], median_a [114:98], median_b [131:115],
  // median_c [148:132], bisector_a [165:149], bisector_b [182:166],
  // bisector_c [199:183]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic       f_valid_w, q_full_w, q_empty_w, pop_w;
  tm_item_t   f_item_w, q_item_w;
  tm_result_t res_w;

  // front end: classify sides, form perimeter and differences
  tm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .side_a_i     (s_axis_tdata_i[SIDE_W-1:0]),
    .side_b_i     (s_axis_tdata_i[2*SIDE_W-1:SIDE_W]),
    .side_c_i     (s_axis_tdata_i[3*SIDE_W-1:2*SIDE_W]),
    .item_valid_o (f_valid_w),
    .item_ready_i (!q_full_w),
    .item_o       (f_item_w)
  );

  // decouples front from back so each stalls on its own
  tm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (f_valid_w),
    .item_i  (f_item_w),
    .full_o  (q_full_w),
    .pop_i   (pop_w),
    .empty_o (q_empty_w),
    .item_o  (q_item_w)
  );

  // back end: products, roots, divisions, result register
  tm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (!q_empty_w),
    .item_i       (q_item_w),
    .pop_o        (pop_w),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res_w)
  );

  // struct is laid out with status at bit 0, so it packs straight onto tdata
  assign m_axis_tdata_o = res_w;

  // rejected triangles carry no metrics
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_w.status != ST_OK) |-> (res_w[OUT_DATA_W-1:STATUS_W] == '0))
    else $error("rejected triangle with non-zero metrics");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_w.status == ST_OK || res_w.status == ST_ZERO ||
                         res_w.status == ST_INEQ))
    else $error("undefined status code");

  a_valid_per: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_w.status == ST_OK) |-> (res_w.per != '0))
    else $error("valid triangle with zero perimeter");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid straight after reset");

endmodule

// ===== rtl/tm_front.sv =====
// Front end: takes sides, checks them and forms perimeter and differences.
module tm_front import tm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [SIDE_W-1:0] side_a_i,
  input  logic [SIDE_W-1:0] side_b_i,
  input  logic [SIDE_W-1:0] side_c_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output tm_item_t          item_o
);

  logic     valid_q;
  tm_item_t item_q, item_d;
  logic [DIF_W-1:0] ab_w, ac_w, bc_w;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    ab_w = DIF_W'(side_a_i) + DIF_W'(side_b_i);
    ac_w = DIF_W'(side_a_i) + DIF_W'(side_c_i);
    bc_w = DIF_W'(side_b_i) + DIF_W'(side_c_i);
    item_d.a   = side_a_i;
    item_d.b   = side_b_i;
    item_d.c   = side_c_i;
    item_d.per = PER_W'(ab_w) + PER_W'(side_c_i);
    item_d.da  = bc_w - DIF_W'(side_a_i);
    item_d.db  = ac_w - DIF_W'(side_b_i);
    item_d.dc  = ab_w - DIF_W'(side_c_i);
    // zero side wins over the inequality check
    if (side_a_i == '0 || side_b_i == '0 || side_c_i == '0) begin
      item_d.status = ST_ZERO;
    end else if (ab_w <= DIF_W'(side_c_i) || ac_w <= DIF_W'(side_b_i) ||
                 bc_w <= DIF_W'(side_a_i)) begin
      item_d.status = ST_INEQ;
    end else begin
      item_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/tm_queue.sv =====
// Short FIFO of classified items between front and back end.
module tm_queue import tm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tm_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output tm_item_t item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  tm_item_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             do_push_w, do_pop_w;

  assign full_o    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign item_o    = mem_q[rd_ptr_q];
  assign do_push_w = push_i && !full_o;
  assign do_pop_w  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push_w) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop_w)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push_w && !do_pop_w) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop_w && !do_push_w) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push_w) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/tm_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module tm_sqrt #(
  parameter int IN_W  = 66,
  parameter int PAY_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [IN_W-1:0]    x_i,
  input  logic [PAY_W-1:0]   pay_i,
  output logic               valid_o,
  output logic [IN_W/2-1:0]  root_o,
  output logic [PAY_W-1:0]   pay_o
);

  localparam int RW = IN_W / 2;

  logic             valid_q [RW];
  logic [IN_W-1:0]  x_q     [RW];
  logic [RW+1:0]    rem_q   [RW];
  logic [RW-1:0]    root_q  [RW];
  logic [PAY_W-1:0] pay_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             valid_in;
    logic [IN_W-1:0]  x_in;
    logic [RW+1:0]    rem_in;
    logic [RW-1:0]    root_in;
    logic [PAY_W-1:0] pay_in;
    logic [RW+1:0]    cat_w, trial_w;
    logic             ge_w;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign x_in     = x_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign pay_in   = pay_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign x_in     = x_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign pay_in   = pay_q[k-1];
    end

    always_comb begin
      cat_w   = {rem_in[RW-1:0], x_in[IN_W-1-2*k -: 2]};
      trial_w = {root_in, 2'b01};
      ge_w    = (cat_w >= trial_w);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in;
        rem_q[k]  <= ge_w ? (cat_w - trial_w) : cat_w;
        root_q[k] <= {root_in[RW-2:0], ge_w};
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign pay_o   = pay_q[RW-1];

endmodule

// ===== rtl/tm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tm_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17,
  parameter int QUO_W = 17,
  parameter int PAY_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [PAY_W-1:0] pay_o
);

  // quotient is known to fit QUO_W bits, so the upper numerator part is below den
  localparam int HI_W = NUM_W - QUO_W;

  logic             valid_q [QUO_W];
  logic [NUM_W-1:0] num_q   [QUO_W];
  logic [DEN_W-1:0] den_q   [QUO_W];
  logic [DEN_W-1:0] rem_q   [QUO_W];
  logic [QUO_W-1:0] quo_q   [QUO_W];
  logic [PAY_W-1:0] pay_q   [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic             valid_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   cat_w, diff_w;
    logic             ge_w;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign num_in   = num_i;
      assign den_in   = den_i;
      assign rem_in   = {{(DEN_W-HI_W){1'b0}}, num_i[NUM_W-1:QUO_W]};
      assign quo_in   = '0;
      assign pay_in   = pay_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign num_in   = num_q[k-1];
      assign den_in   = den_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign pay_in   = pay_q[k-1];
    end

    always_comb begin
      cat_w  = {rem_in, num_in[QUO_W-1-k]};
      diff_w = cat_w - {1'b0, den_in};
      ge_w   = (cat_w >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        rem_q[k] <= ge_w ? diff_w[DEN_W-1:0] : cat_w[DEN_W-1:0];
        quo_q[k] <= {quo_in[QUO_W-2:0], ge_w};
        pay_q[k] <= pay_in;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign pay_o   = pay_q[QUO_W-1];

endmodule

// ===== rtl/tm_back.sv =====
// Back end: product stages, root and divider pipelines, result register.
module tm_back import tm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  tm_item_t   item_i,
  output logic       pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output tm_result_t res_o
);

  localparam int LO2_W = SIDE_W + 1;           // low part of p2
  localparam int LOT_W = SIDE_W + 2;           // low part of per*d
  localparam int QP_W  = P1_W + LO2_W;
  localparam int TLO_W = SQ_W + LOT_W;
  localparam int THI_W = SQ_W + P1_W - LOT_W;

  logic en_w;

  // stage 1
  logic              s1_valid_q;
  tm_status_e        s1_status_q;
  logic [PER_W-1:0]  s1_per_q;
  logic [DIF_W-1:0]  s1_tw_a_q, s1_tw_b_q, s1_tw_c_q;
  logic [DIF_W-1:0]  s1_sum_a_q, s1_sum_b_q, s1_sum_c_q;
  logic [P1_W-1:0]   s1_pd_a_q, s1_pd_b_q, s1_pd_c_q;
  logic [P2_W-1:0]   s1_p2_q;
  logic [SQ_W-1:0]   s1_sq_a_q, s1_sq_b_q, s1_sq_c_q;
  logic [SQ_W-1:0]   s1_yz_a_q, s1_yz_b_q, s1_yz_c_q;
  // stage 2
  logic              s2_valid_q;
  tm_status_e        s2_status_q;
  logic [PER_W-1:0]  s2_per_q;
  logic [DIF_W-1:0]  s2_tw_a_q, s2_tw_b_q, s2_tw_c_q;
  logic [DIF_W-1:0]  s2_sum_a_q, s2_sum_b_q, s2_sum_c_q;
  logic [QP_W-1:0]   s2_qlo_q, s2_qhi_q;
  logic [TLO_W-1:0]  s2_tlo_a_q, s2_tlo_b_q, s2_tlo_c_q;
  logic [THI_W-1:0]  s2_thi_a_q, s2_thi_b_q, s2_thi_c_q;
  logic [MED_W-1:0]  s2_m_a_q, s2_m_b_q, s2_m_c_q;
  // stage 3
  logic              s3_valid_q;
  tm_status_e        s3_status_q;
  logic [PER_W-1:0]  s3_per_q;
  logic [DIF_W-1:0]  s3_tw_a_q, s3_tw_b_q, s3_tw_c_q;
  logic [DIF_W-1:0]  s3_sum_a_q, s3_sum_b_q, s3_sum_c_q;
  logic [SQ_IN_W-1:0] s3_q_q, s3_t_a_q, s3_t_b_q, s3_t_c_q;
  logic [MED_W-1:0]  s3_m_a_q, s3_m_b_q, s3_m_c_q;

  assign en_w  = !res_valid_o || res_ready_i;
  assign pop_o = en_w && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_w) begin
      s1_valid_q <= item_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      // stage 1: side products
      s1_status_q <= item_i.status;
      s1_per_q    <= item_i.per;
      s1_tw_a_q   <= {item_i.a, 1'b0};
      s1_tw_b_q   <= {item_i.b, 1'b0};
      s1_tw_c_q   <= {item_i.c, 1'b0};
      s1_sum_a_q  <= DIF_W'(item_i.b) + DIF_W'(item_i.c);
      s1_sum_b_q  <= DIF_W'(item_i.a) + DIF_W'(item_i.c);
      s1_sum_c_q  <= DIF_W'(item_i.a) + DIF_W'(item_i.b);
      s1_pd_a_q   <= P1_W'(item_i.per) * P1_W'(item_i.da);
      s1_pd_b_q   <= P1_W'(item_i.per) * P1_W'(item_i.db);
      s1_pd_c_q   <= P1_W'(item_i.per) * P1_W'(item_i.dc);
      s1_p2_q     <= P2_W'(item_i.db) * P2_W'(item_i.dc);
      s1_sq_a_q   <= SQ_W'(item_i.a) * SQ_W'(item_i.a);
      s1_sq_b_q   <= SQ_W'(item_i.b) * SQ_W'(item_i.b);
      s1_sq_c_q   <= SQ_W'(item_i.c) * SQ_W'(item_i.c);
      s1_yz_a_q   <= SQ_W'(item_i.b) * SQ_W'(item_i.c);
      s1_yz_b_q   <= SQ_W'(item_i.a) * SQ_W'(item_i.c);
      s1_yz_c_q   <= SQ_W'(item_i.a) * SQ_W'(item_i.b);

      // stage 2: partial products of the radicands, median radicands
      s2_status_q <= s1_status_q;
      s2_per_q    <= s1_per_q;
      s2_tw_a_q   <= s1_tw_a_q;
      s2_tw_b_q   <= s1_tw_b_q;
      s2_tw_c_q   <= s1_tw_c_q;
      s2_sum_a_q  <= s1_sum_a_q;
      s2_sum_b_q  <= s1_sum_b_q;
      s2_sum_c_q  <= s1_sum_c_q;
      s2_qlo_q    <= QP_W'(s1_pd_a_q) * QP_W'(s1_p2_q[LO2_W-1:0]);
      s2_qhi_q    <= QP_W'(s1_pd_a_q) * QP_W'(s1_p2_q[P2_W-1:LO2_W]);
      s2_tlo_a_q  <= TLO_W'(s1_yz_a_q) * TLO_W'(s1_pd_a_q[LOT_W-1:0]);
      s2_tlo_b_q  <= TLO_W'(s1_yz_b_q) * TLO_W'(s1_pd_b_q[LOT_W-1:0]);
      s2_tlo_c_q  <= TLO_W'(s1_yz_c_q) * TLO_W'(s1_pd_c_q[LOT_W-1:0]);
      s2_thi_a_q  <= THI_W'(s1_yz_a_q) * THI_W'(s1_pd_a_q[P1_W-1:LOT_W]);
      s2_thi_b_q  <= THI_W'(s1_yz_b_q) * THI_W'(s1_pd_b_q[P1_W-1:LOT_W]);
      s2_thi_c_q  <= THI_W'(s1_yz_c_q) * THI_W'(s1_pd_c_q[P1_W-1:LOT_W]);
      s2_m_a_q    <= MED_W'({s1_sq_b_q, 1'b0}) + MED_W'({s1_sq_c_q, 1'b0})
                     - MED_W'(s1_sq_a_q);
      s2_m_b_q    <= MED_W'({s1_sq_a_q, 1'b0}) + MED_W'({s1_sq_c_q, 1'b0})
                     - MED_W'(s1_sq_b_q);
      s2_m_c_q    <= MED_W'({s1_sq_a_q, 1'b0}) + MED_W'({s1_sq_b_q, 1'b0})
                     - MED_W'(s1_sq_c_q);

      // stage 3: recombine partial products
      s3_status_q <= s2_status_q;
      s3_per_q    <= s2_per_q;
      s3_tw_a_q   <= s2_tw_a_q;
      s3_tw_b_q   <= s2_tw_b_q;
      s3_tw_c_q   <= s2_tw_c_q;
      s3_sum_a_q  <= s2_sum_a_q;
      s3_sum_b_q  <= s2_sum_b_q;
      s3_sum_c_q  <= s2_sum_c_q;
      s3_q_q      <= SQ_IN_W'(s2_qlo_q) + SQ_IN_W'({s2_qhi_q, {LO2_W{1'b0}}});
      s3_t_a_q    <= SQ_IN_W'(s2_tlo_a_q) + SQ_IN_W'({s2_thi_a_q, {LOT_W{1'b0}}});
      s3_t_b_q    <= SQ_IN_W'(s2_tlo_b_q) + SQ_IN_W'({s2_thi_b_q, {LOT_W{1'b0}}});
      s3_t_c_q    <= SQ_IN_W'(s2_tlo_c_q) + SQ_IN_W'({s2_thi_c_q, {LOT_W{1'b0}}});
      s3_m_a_q    <= s2_m_a_q;
      s3_m_b_q    <= s2_m_b_q;
      s3_m_c_q    <= s2_m_c_q;
    end
  end

  // root pipelines; divisors and side data ride along
  logic              rv_q_w, rv_ta_w, rv_tb_w, rv_tc_w, rv_ma_w, rv_mb_w, rv_mc_w;
  logic              root_valid_w;
  logic [ROOT_W-1:0] r_w, rt_a_w, rt_b_w, rt_c_w, rm_a_w, rm_b_w, rm_c_w;
  tm_status_e        r_status_w;
  logic [PER_W-1:0]  r_per_w;
  logic [DIF_W-1:0]  r_sum_a_w, r_sum_b_w, r_sum_c_w, r_tw_a_w, r_tw_b_w, r_tw_c_w;
  logic [ROOT_W-1:0] area_full_w;

  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(STATUS_W + PER_W)) u_sqrt_q (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(s3_q_q),
    .pay_i({s3_status_q, s3_per_q}), .valid_o(rv_q_w), .root_o(r_w),
    .pay_o({r_status_w, r_per_w})
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_ta (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(s3_t_a_q),
    .pay_i(s3_sum_a_q), .valid_o(rv_ta_w), .root_o(rt_a_w), .pay_o(r_sum_a_w)
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_tb (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(s3_t_b_q),
    .pay_i(s3_sum_b_q), .valid_o(rv_tb_w), .root_o(rt_b_w), .pay_o(r_sum_b_w)
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_tc (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(s3_t_c_q),
    .pay_i(s3_sum_c_q), .valid_o(rv_tc_w), .root_o(rt_c_w), .pay_o(r_sum_c_w)
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_ma (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(SQ_IN_W'(s3_m_a_q)),
    .pay_i(s3_tw_a_q), .valid_o(rv_ma_w), .root_o(rm_a_w), .pay_o(r_tw_a_w)
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_mb (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(SQ_IN_W'(s3_m_b_q)),
    .pay_i(s3_tw_b_q), .valid_o(rv_mb_w), .root_o(rm_b_w), .pay_o(r_tw_b_w)
  );
  tm_sqrt #(.IN_W(SQ_IN_W), .PAY_W(DIF_W)) u_sqrt_mc (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s3_valid_q), .x_i(SQ_IN_W'(s3_m_c_q)),
    .pay_i(s3_tw_c_q), .valid_o(rv_mc_w), .root_o(rm_c_w), .pay_o(r_tw_c_w)
  );

  assign root_valid_w = rv_q_w & rv_ta_w & rv_tb_w & rv_tc_w & rv_ma_w & rv_mb_w & rv_mc_w;
  assign area_full_w  = r_w >> (FRAC_BITS + 2);

  // divider pipelines
  logic              dv_ha_w, dv_hb_w, dv_hc_w, dv_ba_w, dv_bb_w, dv_bc_w, div_valid_w;
  logic [MET_W-1:0]  q_ha_w, q_hb_w, q_hc_w, q_ba_w, q_bb_w, q_bc_w;
  logic [MET_W-1:0]  d_med_a_w, d_med_b_w, d_med_c_w;
  tm_status_e        d_status_w;
  logic [PER_W-1:0]  d_per_w;
  logic [AREA_W-1:0] d_area_w;
  tm_result_t        res_d, res_q;
  logic              res_valid_q;

  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(STATUS_W)) u_div_ha (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(r_w), .den_i(r_tw_a_w),
    .pay_i(r_status_w), .valid_o(dv_ha_w), .quo_o(q_ha_w), .pay_o(d_status_w)
  );
  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(PER_W)) u_div_hb (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(r_w), .den_i(r_tw_b_w),
    .pay_i(r_per_w), .valid_o(dv_hb_w), .quo_o(q_hb_w), .pay_o(d_per_w)
  );
  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(AREA_W)) u_div_hc (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(r_w), .den_i(r_tw_c_w),
    .pay_i(area_full_w[AREA_W-1:0]), .valid_o(dv_hc_w), .quo_o(q_hc_w), .pay_o(d_area_w)
  );
  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(MET_W)) u_div_ba (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(rt_a_w),
    .den_i(r_sum_a_w), .pay_i(rm_a_w[MET_W:1]), .valid_o(dv_ba_w), .quo_o(q_ba_w),
    .pay_o(d_med_a_w)
  );
  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(MET_W)) u_div_bb (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(rt_b_w),
    .den_i(r_sum_b_w), .pay_i(rm_b_w[MET_W:1]), .valid_o(dv_bb_w), .quo_o(q_bb_w),
    .pay_o(d_med_b_w)
  );
  tm_div #(.NUM_W(ROOT_W), .DEN_W(DIF_W), .QUO_W(MET_W), .PAY_W(MET_W)) u_div_bc (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(root_valid_w), .num_i(rt_c_w),
    .den_i(r_sum_c_w), .pay_i(rm_c_w[MET_W:1]), .valid_o(dv_bc_w), .quo_o(q_bc_w),
    .pay_o(d_med_c_w)
  );

  assign div_valid_w = dv_ha_w & dv_hb_w & dv_hc_w & dv_ba_w & dv_bb_w & dv_bc_w;

  always_comb begin
    res_d = '0;
    res_d.status = d_status_w;
    if (d_status_w == ST_OK) begin
      res_d.per   = d_per_w;
      res_d.area  = d_area_w;
      res_d.hgt_a = q_ha_w;
      res_d.hgt_b = q_hb_w;
      res_d.hgt_c = q_hc_w;
      res_d.med_a = d_med_a_w;
      res_d.med_b = d_med_b_w;
      res_d.med_c = d_med_c_w;
      res_d.bis_a = q_ba_w;
      res_d.bis_b = q_bb_w;
      res_d.bis_c = q_bc_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (en_w) begin
      res_valid_q <= div_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w && div_valid_w) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== tb/tb_triangle_metrics.sv =====
// Self-checking testbench of the triangle metrics engine: stream stimulus, predictor, scoreboard.
module tb_triangle_metrics;
  import tm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 60;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 500;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // side_a, side_b, side_c from bit 0 up
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // status, perimeter, area, heights a..c, medians a..c, bisectors a..c
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  triangle_metrics dut (.*);

  always #6 clk_i = ~clk_i;

  // Stimulus row: sides, with a hand-typed expectation where it is obvious.
  typedef struct {
    logic [SIDE_W-1:0] a, b, c;
    bit                typed;
    tm_result_t        res;
  } tri_row_t;

  tm_result_t metrics_due[$];
  int         n_fail = 0;
  int         n_seen = 0;
  int         n_valid_seen = 0;
  longint     cycles = 0;

  // Exact floor square root of a radicand up to 128 bits.
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  // Predicted metrics of one triangle.
  function automatic tm_result_t triangle_metrics_of(logic [SIDE_W-1:0] sa,
                                                     logic [SIDE_W-1:0] sb,
                                                     logic [SIDE_W-1:0] sc);
    tm_result_t   res;
    logic [127:0] a, b, c, per, q;
    logic [63:0]  rt;
    res = '0;
    a = 128'(sa); b = 128'(sb); c = 128'(sc);
    if (a == 0 || b == 0 || c == 0) begin
      res.status = ST_ZERO;
    end else if (a + b <= c || a + c <= b || b + c <= a) begin
      res.status = ST_INEQ;
    end else begin
      per = a + b + c;
      q   = per * (b + c - a) * (a + c - b) * (a + b - c);
      rt  = isqrt(q);
      res.status = ST_OK;
      res.per    = PER_W'(per);
      res.area   = AREA_W'(rt >> (FRAC_BITS_DEF + 2));
      res.hgt_a  = MET_W'(rt / (2 * a));
      res.hgt_b  = MET_W'(rt / (2 * b));
      res.hgt_c  = MET_W'(rt / (2 * c));
      res.med_a  = MET_W'(isqrt(2*b*b + 2*c*c - a*a) >> 1);
      res.med_b  = MET_W'(isqrt(2*a*a + 2*c*c - b*b) >> 1);
      res.med_c  = MET_W'(isqrt(2*a*a + 2*b*b - c*c) >> 1);
      res.bis_a  = MET_W'(isqrt(b * c * per * (b + c - a)) / (b + c));
      res.bis_b  = MET_W'(isqrt(a * c * per * (a + c - b)) / (a + c));
      res.bis_c  = MET_W'(isqrt(a * b * per * (a + b - c)) / (a + b));
    end
    return res;
  endfunction

  function automatic tri_row_t row(int a, int b, int c);
    tri_row_t r;
    r.a = SIDE_W'(a); r.b = SIDE_W'(b); r.c = SIDE_W'(c);
    r.typed = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic tri_row_t row_fixed(int a, int b, int c, tm_status_e st);
    tri_row_t r;
    r = row(a, b, c);
    r.typed = 1'b1;
    r.res.status = st;
    return r;
  endfunction

  tri_row_t directed[$];
  tri_row_t triangles[$];

  initial begin
    // zero sides come before the inequality check
    directed.push_back(row_fixed(0, 0, 0, ST_ZERO));
    directed.push_back(row_fixed(0, 5, 5, ST_ZERO));
    directed.push_back(row_fixed(7, 0, 7, ST_ZERO));
    directed.push_back(row_fixed(9, 9, 0, ST_ZERO));
    directed.push_back(row_fixed(0, 65535, 1, ST_ZERO));
    // degenerate and violated, each side the long one
    directed.push_back(row_fixed(1, 1, 2, ST_INEQ));
    directed.push_back(row_fixed(3, 10, 7, ST_INEQ));
    directed.push_back(row_fixed(20, 4, 5, ST_INEQ));
    directed.push_back(row_fixed(65535, 1, 1, ST_INEQ));
    directed.push_back(row_fixed(1, 65535, 65534, ST_INEQ));
    // valid extremes
    directed.push_back(row(1, 1, 1));
    directed.push_back(row(65535, 65535, 65535));
    directed.push_back(row(65535, 65535, 1));
    directed.push_back(row(1, 65535, 65535));
    directed.push_back(row(65535, 1, 65535));
    directed.push_back(row(48, 64, 80));
    directed.push_back(row(32768, 32768, 65535));
    directed.push_back(row(43690, 21845, 65534));
    directed.push_back(row(2, 3, 4));
    directed.push_back(row(16, 16, 16));
    foreach (directed[i]) triangles.push_back(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      int a, b, c, lo, hi, k;
      k = $urandom_range(0, 9);
      a = $urandom_range(1, 65535);
      b = $urandom_range(1, 65535);
      if (k < 7) begin
        // mostly valid triangles: c strictly between |a-b| and a+b
        lo = (a > b ? a - b : b - a) + 1;
        hi = a + b - 1;
        if (hi > 65535) hi = 65535;
        c = (lo <= hi) ? $urandom_range(lo, hi) : a;
      end else if (k == 7) begin
        c = a + b;
        if (c > 65535) c = (a > b) ? a - b : b - a;
        if (c == 0) c = a;
      end else if (k == 8) begin
        c = $urandom_range(0, 65535);
      end else begin
        a = $urandom_range(1, 16); b = $urandom_range(1, 16);
        c = $urandom_range(0, 16);
      end
      triangles.push_back(row(a, b, c));
    end
  end

  // Sender: bursts with random gaps.
  initial begin
    int burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst = 0;
    foreach (triangles[i]) begin
      if (burst == 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 24);
      end
      burst--;
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {triangles[i].c, triangles[i].b, triangles[i].a};
      metrics_due.push_back(triangles[i].typed ? triangles[i].res
        : triangle_metrics_of(triangles[i].a, triangles[i].b, triangles[i].c));
      // ready is settled mid-cycle and holds until the next rising edge
      @(negedge clk_i);
      while (!s_axis_tready_o) @(negedge clk_i);
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b0;
    while (metrics_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    $display("Covered %0d triangles (%0d directed), %0d valid results checked.",
             triangles.size(), directed.size(), n_valid_seen);
    if (n_fail == 0 && n_seen == triangles.size())
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Receiver stall pattern: calm stretches and choppy ones.
  always @(posedge clk_i) begin
    if ((cycles / 256) % 3 == 0) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(0, 3) != 0);
  end

  // Scoreboard on accepted result transfers.
  always @(posedge clk_i) begin
    tm_result_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      n_seen++;
      if (metrics_due.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        want = metrics_due.pop_front();
        if (want.status == ST_OK) n_valid_seen++;
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); n_fail++; end
        if (got.per !== want.per) begin
          $error("perimeter exp %0d got %0d", want.per, got.per); n_fail++; end
        if (got.area !== want.area) begin
          $error("area exp %0d got %0d", want.area, got.area); n_fail++; end
        if (got.hgt_a !== want.hgt_a) begin
          $error("height_a exp %0d got %0d", want.hgt_a, got.hgt_a); n_fail++; end
        if (got.hgt_b !== want.hgt_b) begin
          $error("height_b exp %0d got %0d", want.hgt_b, got.hgt_b); n_fail++; end
        if (got.hgt_c !== want.hgt_c) begin
          $error("height_c exp %0d got %0d", want.hgt_c, got.hgt_c); n_fail++; end
        if (got.med_a !== want.med_a) begin
          $error("median_a exp %0d got %0d", want.med_a, got.med_a); n_fail++; end
        if (got.med_b !== want.med_b) begin
          $error("median_b exp %0d got %0d", want.med_b, got.med_b); n_fail++; end
        if (got.med_c !== want.med_c) begin
          $error("median_c exp %0d got %0d", want.med_c, got.med_c); n_fail++; end
        if (got.bis_a !== want.bis_a) begin
          $error("bisector_a exp %0d got %0d", want.bis_a, got.bis_a); n_fail++; end
        if (got.bis_b !== want.bis_b) begin
          $error("bisector_b exp %0d got %0d", want.bis_b, got.bis_b); n_fail++; end
        if (got.bis_c !== want.bis_c) begin
          $error("bisector_c exp %0d got %0d", want.bis_c, got.bis_c); n_fail++; end
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/tm_pkg.sv
rtl/tm_front.sv
rtl/tm_queue.sv
rtl/tm_sqrt.sv
rtl/tm_div.sv
rtl/tm_back.sv
rtl/triangle_metrics.sv
tb/tb_triangle_metrics.sv
